@@ rtl/core/gb5_pkg.sv @@
// ----------------------------------------------------------------------------
// gb5_pkg: shared definitions for the 5x5 Gaussian blur
// Pixel and control types, kernel weights, divider constants and register
// indexes used by the blur core and its submodules.
// ----------------------------------------------------------------------------
package gb5_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 16;
  localparam int EFFW_W       = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

  localparam int PIX_W      = 24;
  localparam int STORE_ROWS = 4;
  localparam int WORD_W     = STORE_ROWS * PIX_W;
  localparam int KSIZE      = 5;
  localparam int NUM_CHAN   = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;

  // Largest column sum is 107 * 255, largest total is 273 * 255.
  localparam int COLSUM_W = 15;
  localparam int SUM_W    = 17;

  // Division by the kernel total as a multiply by a rounded-up reciprocal.
  // The error term times the largest sum stays below 2^DIV_SHIFT, so the
  // quotient is exact.
  localparam int KERNEL_TOTAL = 273;
  localparam int DIV_SHIFT    = 25;
  localparam int DIV_MULT     = (2 ** DIV_SHIFT + KERNEL_TOTAL - 1) / KERNEL_TOTAL;
  localparam int MULT_W       = $clog2(DIV_MULT + 1);
  localparam int PROD_W       = SUM_W + MULT_W;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [KSIZE-1:0] col_ok;
    logic [KSIZE-1:0] row_ok;
  } tap_ctrl_t;

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } result_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Indexed [row][column].
  localparam logic [5:0] GAUSS_W [KSIZE][KSIZE] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

endpackage

@@ rtl/core/gb5_line_store.sv @@
// ----------------------------------------------------------------------------
// gb5_line_store: four-row line memory
// One word per column holds the four previous rows of that column. Registered
// read with write-to-read bypass, and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module gb5_line_store import gb5_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [COL_W-1:0]  wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  output logic              clearing
);

  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [COL_W-1:0]  clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // With a one-pixel row the same column is read right as it is written.
    if (rd_en) begin
      rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/gb5_kernel.sv @@
// ----------------------------------------------------------------------------
// gb5_kernel: 5x5 window and weighted sum
// Shifts column vectors into the window, forms masked weighted column sums,
// adds them and divides by the kernel total.
// ----------------------------------------------------------------------------
module gb5_kernel import gb5_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   vec_valid,
  input  pixel_t [KSIZE-1:0]     vec,
  input  tap_ctrl_t              ctrl,
  output logic                   res_valid,
  output result_t                res
);

  function automatic chan_t chan_of(input pixel_t p, input int c);
    chan_t v;
    case (c)
      0:       v = p.red;
      1:       v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  pixel_t            win [KSIZE][KSIZE];  // [column][row]
  logic              s2_valid;
  tap_ctrl_t         s2_ctrl;
  logic              s3_valid;
  logic              s3_last;
  logic [COLSUM_W-1:0] colsum [NUM_CHAN][KSIZE];
  logic [COLSUM_W-1:0] colsum_next [NUM_CHAN][KSIZE];
  logic              s4_valid;
  logic              s4_last;
  logic [SUM_W-1:0]  s4_sum [NUM_CHAN];
  logic [SUM_W-1:0]  sum_next [NUM_CHAN];
  logic [PROD_W-1:0] prod [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < KSIZE; p++) begin
        for (int q = 0; q < KSIZE; q++) begin
          win[p][q] <= '0;
        end
      end
    end else if (adv && vec_valid) begin
      for (int p = 0; p < KSIZE - 1; p++) begin
        for (int q = 0; q < KSIZE; q++) begin
          win[p][q] <= win[p+1][q];
        end
      end
      for (int q = 0; q < KSIZE; q++) begin
        win[KSIZE-1][q] <= vec[q];
      end
    end
  end

  // Taps outside the image contribute nothing; the divisor stays fixed.
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      for (int p = 0; p < KSIZE; p++) begin
        colsum_next[c][p] = '0;
        for (int q = 0; q < KSIZE; q++) begin
          if (s2_ctrl.col_ok[p] && s2_ctrl.row_ok[q]) begin
            colsum_next[c][p] = colsum_next[c][p] +
                COLSUM_W'(GAUSS_W[q][p]) * COLSUM_W'(chan_of(win[p][q], c));
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum_next[c] = '0;
      for (int p = 0; p < KSIZE; p++) begin
        sum_next[c] = sum_next[c] + SUM_W'(colsum[c][p]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= vec_valid && ctrl.emit;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctrl <= ctrl;
      s3_last <= s2_ctrl.last;
      colsum  <= colsum_next;
      s4_last <= s3_last;
      s4_sum  <= sum_next;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod[c] = PROD_W'(s4_sum[c]) * PROD_W'(DIV_MULT);
    end
  end

  assign res_valid     = s4_valid;
  assign res.pix.red   = prod[0][DIV_SHIFT +: 8];
  assign res.pix.green = prod[1][DIV_SHIFT +: 8];
  assign res.pix.blue  = prod[2][DIV_SHIFT +: 8];
  assign res.last      = s4_last;

endmodule

@@ rtl/core/gaussian_blur_5x5.sv @@
// ----------------------------------------------------------------------------
// gaussian_blur_5x5: streaming 5x5 Gaussian blur of RGB pixels
// Takes one pixel per clock in raster order, unless stalled, and returns one
// blurred pixel per clock once the window has filled: the result for image
// position k leaves with input item k + 2*width + 2, so the host follows the
// last pixel of a frame with 2*width + 2 padding items. From the accepting
// edge to m_tvalid the line-store read registers at the accepting edge
// itself, then come the window shift, the column sums, the total, and the
// reciprocal multiply into the output buffer. A finished pixel waits in a
// two-entry output buffer, and apart from the reset sweep the input stalls
// only while both entries are full. After reset the line store is zeroed in
// a sweep over all 4096 columns with s_tready low; register writes are taken
// during that time. Taps outside the image count as zero and the sum is
// always divided by 273, truncating.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5 import gb5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic        s_tuser,   // is_padding
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic        m_tlast,   // last_pixel
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  function automatic logic [15:0] bump_row(input logic [15:0] r);
    return (r == 16'hFFFF) ? r : r + 16'd1;
  endfunction

  // Configuration registers.
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  reg_idx_t                cfg_sel;

  assign cfg_sel = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_sel)
        REG_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      default:    prdata = '0;
    endcase
  end

  logic [EFFW_W-1:0]       w_raw;
  logic [EFFW_W-1:0]       w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;

  assign w_raw = EFFW_W'(image_width);
  assign h_eff = (image_height == '0) ? HEIGHT_REG_W'(1) : image_height;

  always_comb begin
    if (w_raw == '0) begin
      w_eff = EFFW_W'(1);
    end else if (w_raw > EFFW_W'(MAX_WIDTH)) begin
      w_eff = EFFW_W'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
  end

  // Flow control.
  logic    adv;
  logic    clearing;
  logic    accept;
  logic    item;
  logic    stray;
  logic    out_valid;
  result_t out_data;
  logic    sk_valid;
  result_t sk_data;

  assign adv      = !sk_valid;
  assign s_tready = adv && !clearing;
  assign accept   = s_tvalid && s_tready;

  // Input and output positions.
  logic [COL_W-1:0] in_column;
  logic [15:0]      in_row;
  logic [COL_W-1:0] out_column;
  logic [15:0]      out_row;

  logic              in_wrap;
  logic              out_wrap;
  logic [COL_W-1:0]  ic0;
  logic [15:0]       ir0;
  logic [COL_W-1:0]  oc0;
  logic [15:0]       or0;
  logic [EFFW_W-1:0] ic_inc;
  logic [EFFW_W-1:0] oc_inc;
  logic              in_end;
  logic              out_end;
  logic              early;
  tap_ctrl_t         ctrl0;
  logic [EFFW_W-1:0] oc_tap;
  logic [16:0]       or_tap;

  // A padding item with no frame in progress is dropped without effect.
  assign stray = s_tuser && (in_row == '0) && (in_column == '0);
  assign item  = accept && !stray;

  always_comb begin
    in_wrap  = EFFW_W'(in_column) >= w_eff;
    out_wrap = EFFW_W'(out_column) >= w_eff;
    ic0      = in_wrap ? '0 : in_column;
    ir0      = in_wrap ? bump_row(in_row) : in_row;
    oc0      = out_wrap ? '0 : out_column;
    or0      = out_wrap ? bump_row(out_row) : out_row;
    ic_inc   = EFFW_W'(ic0) + EFFW_W'(1);
    oc_inc   = EFFW_W'(oc0) + EFFW_W'(1);
    in_end   = ic_inc >= w_eff;
    out_end  = oc_inc >= w_eff;

    // The first output appears once 2*width+2 positions have gone in.
    early = (ir0 == 16'd0) || (ir0 == 16'd1) ||
            ((ir0 == 16'd2) && (ic0 < COL_W'(2))) ||
            ((ir0 == 16'd3) && (w_eff == EFFW_W'(1)));

    ctrl0.emit = !early;
    ctrl0.last = !early && (or0 >= h_eff - 16'd1) &&
                 (EFFW_W'(oc0) == w_eff - EFFW_W'(1));
    for (int p = 0; p < KSIZE; p++) begin
      oc_tap = EFFW_W'(oc0) + EFFW_W'(p);
      or_tap = {1'b0, or0} + 17'(p);
      ctrl0.col_ok[p] = (oc_tap >= EFFW_W'(2)) && (oc_tap < w_eff + EFFW_W'(2));
      ctrl0.row_ok[p] = (or_tap >= 17'd2) && (or_tap < {1'b0, h_eff} + 17'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (item) begin
      if (ctrl0.last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        in_column <= in_end ? '0 : ic_inc[COL_W-1:0];
        in_row    <= in_end ? bump_row(ir0) : ir0;
        if (ctrl0.emit) begin
          out_column <= out_end ? '0 : oc_inc[COL_W-1:0];
          out_row    <= out_end ? bump_row(or0) : or0;
        end else begin
          out_column <= oc0;
          out_row    <= or0;
        end
      end
    end
  end

  // First stage: pixel and its column of stored rows.
  logic              s1_valid;
  pixel_t            s1_pix;
  tap_ctrl_t         s1_ctrl;
  logic [COL_W-1:0]  s1_addr;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] wr_word;
  pixel_t [KSIZE-1:0] vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (item) begin
      s1_pix  <= s_tuser ? pixel_t'('0) : pixel_t'(s_tdata);
      s1_ctrl <= ctrl0;
      s1_addr <= ic0;
    end
  end

  // Oldest row first; the newest row is the incoming pixel.
  always_comb begin
    for (int q = 0; q < STORE_ROWS; q++) begin
      vec[q] = rd_data[(STORE_ROWS - 1 - q) * PIX_W +: PIX_W];
    end
    vec[KSIZE-1] = s1_pix;
    wr_word = {rd_data[WORD_W-PIX_W-1:0], s1_pix};
  end

  gb5_line_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (item),
    .rd_addr  (ic0),
    .rd_data  (rd_data),
    .wr_en    (s1_valid && adv),
    .wr_addr  (s1_addr),
    .wr_data  (wr_word),
    .clearing (clearing)
  );

  logic    res_valid;
  result_t res;

  gb5_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .vec_valid (s1_valid),
    .vec       (vec),
    .ctrl      (s1_ctrl),
    .res_valid (res_valid),
    .res       (res)
  );

  // Two-entry output buffer. The pipeline freezes only while the skid
  // entry is occupied, so it never pushes into a full buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid && adv) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_data <= sk_valid ? sk_data : res;
    end else if (res_valid && adv) begin
      sk_data <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data.pix;
  assign m_tlast  = out_data.last;

endmodule

@@ rtl/core/gb5_checker.sv @@
// ----------------------------------------------------------------------------
// gb5_checker: port-level checks for the Gaussian blur
// Watches the ports of the blur core over time; attached by bind.
// ----------------------------------------------------------------------------
module gb5_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // The line store is swept after reset, so no word is taken right away.
  a_ready_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("s_tready high in the cycle after reset");

  // Reset empties the output buffer.
  a_no_output_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high in the cycle after reset");

  // A stalled result word holds.
  a_output_holds: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  // A width write reads back in the next cycle.
  a_width_readback: assert property (@(posedge clk) disable iff (rst)
      (psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
      |-> prdata[12:0] == $past(pwdata[12:0]))
    else $error("image width read back wrong");

endmodule

bind gaussian_blur_5x5 gb5_checker u_gb5_checker (.*);
